// File: design/lcsb_pkg.sv
package lcsb_pkg;

    // sizing
    localparam int MAX_CELLS     = 1024;
    localparam int MAX_FACES     = 2048;
    localparam int CELL_W        = 10;
    localparam int FACE_W        = 11;
    localparam int FACE_CNT_W    = 12;
    localparam int ROWS_W        = 11;
    localparam int VIDX_W        = 13;
    localparam int SUM_W         = VIDX_W + 1;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 11;
    localparam int HEAD_NEXT_IDX = (MAX_FACES > 1) ? 1 : 0;

    // configuration register indices
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC = CFG_IDX_W'(1);

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EMIT = 1'b1
    } lcsb_cmd_t;

    typedef struct packed {
        lcsb_cmd_t          cmd;
        logic [CELL_W-1:0]  owner_cell;
        logic [CELL_W-1:0]  neighbour_cell;
    } lcsb_in_t;

    typedef struct packed {
        logic [CELL_W-1:0]  entry_row;
        logic [CELL_W-1:0]  entry_col;
        logic [VIDX_W-1:0]  value_index;
        logic               last_entry;
    } lcsb_out_t;

    // one sorted list entry
    typedef struct packed {
        logic [CELL_W-1:0]  row;
        logic [CELL_W-1:0]  col;
        logic [FACE_W-1:0]  face;
    } lcsb_entry_t;

    // control broadcast along a sorting chain
    typedef struct packed {
        logic        insert;
        logic        pop;
        lcsb_entry_t item;
    } lcsb_chain_ctrl_t;

    // true when the stored entry sorts strictly after the new key
    function automatic logic key_after(lcsb_entry_t e, lcsb_entry_t k);
        return {e.row, e.col} > {k.row, k.col};
    endfunction

endpackage

// File: design/lcsb_sort_cell.sv
module lcsb_sort_cell (
    input  logic                      aclk,
    input  lcsb_pkg::lcsb_chain_ctrl_t ctrl,
    input  logic                      beyond,
    input  logic                      prev_after,
    input  lcsb_pkg::lcsb_entry_t     prev_entry,
    input  lcsb_pkg::lcsb_entry_t     next_entry,
    output logic                      after,
    output lcsb_pkg::lcsb_entry_t     entry
);
    import lcsb_pkg::*;

    lcsb_entry_t entry_reg;
    lcsb_entry_t entry_next;

    // unused slots count as sorting after everything
    assign after = beyond || key_after(entry_reg, ctrl.item);

    // insert shifts towards the tail, pop shifts towards the head
    always_comb begin
        entry_next = entry_reg;
        if (ctrl.insert) begin
            if (after) begin
                entry_next = prev_after ? prev_entry : ctrl.item;
            end
        end else if (ctrl.pop) begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: design/lcsb_sort_chain.sv
module lcsb_sort_chain (
    input  logic                                aclk,
    input  lcsb_pkg::lcsb_chain_ctrl_t          ctrl,
    input  logic [lcsb_pkg::FACE_CNT_W-1:0]     count,
    output lcsb_pkg::lcsb_entry_t               head,
    output lcsb_pkg::lcsb_entry_t               head_next
);
    import lcsb_pkg::*;

    logic [MAX_FACES-1:0] after;
    lcsb_entry_t          entries [MAX_FACES];

    // row of cells, each talking to its two neighbours
    genvar i;
    generate
        for (i = 0; i < MAX_FACES; i++) begin : g_cell
            logic        beyond;
            logic        prev_after;
            lcsb_entry_t prev_entry;
            lcsb_entry_t next_entry;

            assign beyond = (count <= FACE_CNT_W'(i));

            if (i == 0) begin : g_first
                assign prev_after = 1'b0;
                assign prev_entry = ctrl.item;
            end else begin : g_rest
                assign prev_after = after[i-1];
                assign prev_entry = entries[i-1];
            end

            if (i == MAX_FACES - 1) begin : g_tail
                assign next_entry = entries[i];
            end else begin : g_body
                assign next_entry = entries[i+1];
            end

            lcsb_sort_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .beyond     (beyond),
                .prev_after (prev_after),
                .prev_entry (prev_entry),
                .next_entry (next_entry),
                .after      (after[i]),
                .entry      (entries[i])
            );
        end
    endgenerate

    assign head      = entries[0];
    assign head_next = entries[HEAD_NEXT_IDX];

endmodule

// File: design/ldu_to_coo_sparsity_builder_unit.sv
// Coordinate sparsity builder for face-addressed matrices.
// Input channel s_*: cmd load carries one face (owner, neighbour); cmd emit
// asks for the next coordinate entry. Result channel m_*: one entry per
// emit that finds an entry, with row, column, value index and a last flag; loads give nothing.
// Configuration channel cfg_*: index 0 row_count, index 1 symmetric_mode,
// always ready; the user must write it only while no transaction is in flight, as the block does not enforce this.
// Each face is inserted into two chains of sorting cells (upper and lower
// lists); every cell compares against the broadcast key and shifts one place
// along when it sorts after it. Emitting a lower or upper entry pops the head
// of that chain; diagonal entries pop nothing.
// Throughput: one input transaction per cycle while s_ready is high; the result
// of an accepted emit appears on m_valid in the next cycle, from the output register.
// When the receiver stalls, the result register holds and s_ready drops
// until the result is taken. After the entry flagged last_entry, or an emit
// with nothing left, the block empties and takes loads again.
// Reset clears the face count, cursors, phase, run flag, configuration registers and
// the output valid flag; the output payload and list contents are not cleared.
module ldu_to_coo_sparsity_builder_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  lcsb_pkg::lcsb_in_t               s_payload,
    output logic                             m_valid,
    input  logic                             m_ready,
    output lcsb_pkg::lcsb_out_t              m_payload,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lcsb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lcsb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lcsb_pkg::*;

    typedef enum logic [1:0] {
        PH_LOWER = 2'd0,
        PH_DIAG  = 2'd1,
        PH_UPPER = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EK_NONE,
        EK_LOWER,
        EK_DIAG,
        EK_UPPER
    } emit_kind_t;

    // state
    logic [FACE_CNT_W-1:0] faces_reg,     faces_next;
    logic [ROWS_W-1:0]     cursor_reg,    cursor_next;
    logic [FACE_CNT_W-1:0] up_ptr_reg,    up_ptr_next;
    logic [FACE_CNT_W-1:0] lo_ptr_reg,    lo_ptr_next;
    phase_t                phase_reg,     phase_next;
    logic                  run_reg,       run_next;
    logic [ROWS_W-1:0]     row_count_reg, row_count_next;
    logic                  sym_reg,       sym_next;
    logic                  m_valid_reg,   m_valid_next;
    lcsb_out_t             m_payload_reg, m_payload_next;

    lcsb_chain_ctrl_t up_ctrl, lo_ctrl;
    lcsb_entry_t      up_head, up_head1, lo_head, lo_head1;

    logic             s_fire, load_fire, emit_fire;
    logic [ROWS_W-1:0] rows_eff, r1, x, x1;
    logic             lo_avail, up_avail, up_avail2;
    logic             lo_has_r, lo_has_r1, up_has_r, up_has_x, up_has2_x;
    emit_kind_t       kind;
    lcsb_out_t        res;
    logic [SUM_W-1:0] vsum;
    logic             emit_done;

    // handshakes
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign load_fire = s_fire && (s_payload.cmd == CMD_LOAD) && !run_reg
                       && (faces_reg < FACE_CNT_W'(MAX_FACES));
    assign emit_fire = s_fire && (s_payload.cmd == CMD_EMIT);
    assign cfg_ready = 1'b1;

    // sorting chains
    always_comb begin
        up_ctrl.insert    = load_fire;
        up_ctrl.pop       = emit_fire && (kind == EK_UPPER);
        up_ctrl.item.row  = s_payload.owner_cell;
        up_ctrl.item.col  = s_payload.neighbour_cell;
        up_ctrl.item.face = faces_reg[FACE_W-1:0];
        lo_ctrl.insert    = load_fire;
        lo_ctrl.pop       = emit_fire && (kind == EK_LOWER);
        lo_ctrl.item.row  = s_payload.neighbour_cell;
        lo_ctrl.item.col  = s_payload.owner_cell;
        lo_ctrl.item.face = faces_reg[FACE_W-1:0];
    end

    lcsb_sort_chain u_upper (
        .aclk      (aclk),
        .ctrl      (up_ctrl),
        .count     (faces_reg),
        .head      (up_head),
        .head_next (up_head1)
    );

    lcsb_sort_chain u_lower (
        .aclk      (aclk),
        .ctrl      (lo_ctrl),
        .count     (faces_reg),
        .head      (lo_head),
        .head_next (lo_head1)
    );

    // effective row count and head checks
    assign rows_eff  = (row_count_reg > ROWS_W'(MAX_CELLS)) ? ROWS_W'(MAX_CELLS)
                                                            : row_count_reg;
    assign r1        = cursor_reg + ROWS_W'(1);
    assign lo_avail  = lo_ptr_reg < faces_reg;
    assign up_avail  = up_ptr_reg < faces_reg;
    assign up_avail2 = (up_ptr_reg + FACE_CNT_W'(1)) < faces_reg;
    assign lo_has_r  = lo_avail && (ROWS_W'(lo_head.row) == cursor_reg);
    assign lo_has_r1 = lo_avail && (ROWS_W'(lo_head.row) == r1);
    assign up_has_r  = up_avail && (ROWS_W'(up_head.row) == cursor_reg);

    // pick the next entry from phase and list heads
    always_comb begin
        kind = EK_NONE;
        x    = cursor_reg;
        case (phase_reg)
            PH_LOWER: begin
                if (cursor_reg < rows_eff) begin
                    kind = lo_has_r ? EK_LOWER : EK_DIAG;
                end
            end
            PH_DIAG: begin
                if (cursor_reg < rows_eff) begin
                    kind = EK_DIAG;
                end
            end
            PH_UPPER: begin
                if (cursor_reg < rows_eff) begin
                    if (up_has_r) begin
                        kind = EK_UPPER;
                    end else if (r1 < rows_eff) begin
                        x    = r1;
                        kind = lo_has_r1 ? EK_LOWER : EK_DIAG;
                    end
                end
            end
            default: begin
                kind = EK_NONE;
            end
        endcase
    end

    assign x1        = x + ROWS_W'(1);
    assign up_has_x  = up_avail && (ROWS_W'(up_head.row) == x);
    assign up_has2_x = up_avail2 && (ROWS_W'(up_head1.row) == x);

    // build the result entry
    always_comb begin
        vsum           = '0;
        res.entry_row  = x[CELL_W-1:0];
        res.entry_col  = x[CELL_W-1:0];
        res.last_entry = 1'b0;
        case (kind)
            EK_LOWER: begin
                res.entry_col = lo_head.col;
                vsum = sym_reg ? SUM_W'(lo_head.face)
                               : SUM_W'(faces_reg) + SUM_W'(lo_head.face);
            end
            EK_DIAG: begin
                vsum = (sym_reg ? SUM_W'(faces_reg) : SUM_W'({faces_reg, 1'b0}))
                       + SUM_W'(x);
                res.last_entry = (x1 >= rows_eff) && !up_has_x;
            end
            EK_UPPER: begin
                res.entry_col  = up_head.col;
                vsum           = SUM_W'(up_head.face);
                res.last_entry = (x1 >= rows_eff) && !up_has2_x;
            end
            default: begin
                vsum = '0;
            end
        endcase
        res.value_index = vsum[VIDX_W-1:0];
    end

    // block empties on the last entry or when nothing is left
    assign emit_done = (kind == EK_NONE) || res.last_entry;

    // next state
    always_comb begin
        faces_next     = faces_reg;
        cursor_next    = cursor_reg;
        up_ptr_next    = up_ptr_reg;
        lo_ptr_next    = lo_ptr_reg;
        phase_next     = phase_reg;
        run_next       = run_reg;
        row_count_next = row_count_reg;
        sym_next       = sym_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;

        // configuration writes
        if (cfg_valid) begin
            case (cfg_index)
                CFG_ROW_COUNT: row_count_next = cfg_data[ROWS_W-1:0];
                CFG_SYMMETRIC: sym_next       = cfg_data[0];
                default:       row_count_next = row_count_reg;
            endcase
        end

        if (load_fire) begin
            faces_next = faces_reg + FACE_CNT_W'(1);
        end

        if (emit_fire) begin
            if (kind != EK_NONE) begin
                m_valid_next   = 1'b1;
                m_payload_next = res;
            end
            if (emit_done) begin
                faces_next  = '0;
                cursor_next = '0;
                up_ptr_next = '0;
                lo_ptr_next = '0;
                phase_next  = PH_LOWER;
                run_next    = 1'b0;
            end else begin
                run_next    = 1'b1;
                cursor_next = x;
                phase_next  = (kind == EK_LOWER) ? PH_LOWER : PH_UPPER;
                if (kind == EK_LOWER) begin
                    lo_ptr_next = lo_ptr_reg + FACE_CNT_W'(1);
                end
                if (kind == EK_UPPER) begin
                    up_ptr_next = up_ptr_reg + FACE_CNT_W'(1);
                end
            end
        end
    end

    // state and output registers
    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
        if (!aresetn) begin
            faces_reg     <= '0;
            cursor_reg    <= '0;
            up_ptr_reg    <= '0;
            lo_ptr_reg    <= '0;
            phase_reg     <= PH_LOWER;
            run_reg       <= 1'b0;
            row_count_reg <= '0;
            sym_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            faces_reg     <= faces_next;
            cursor_reg    <= cursor_next;
            up_ptr_reg    <= up_ptr_next;
            lo_ptr_reg    <= lo_ptr_next;
            phase_reg     <= phase_next;
            run_reg       <= run_next;
            row_count_reg <= row_count_next;
            sym_reg       <= sym_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// File: design/lcsb_checker.sv
module lcsb_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input lcsb_pkg::lcsb_in_t               s_payload,
    input logic                             m_valid,
    input logic                             m_ready
);
    import lcsb_pkg::*;

    // a stalled result stays offered
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped while stalled");

    // a new result only follows an accepted emit transaction
    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && (s_payload.cmd == CMD_EMIT)))
        else $error("result without an emit transaction");

    // a load never produces a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_payload.cmd == CMD_LOAD) && !(m_valid && !m_ready))
        |=> !m_valid)
        else $error("result after a load transaction");

    // input side is free whenever the output register is empty
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

endmodule

bind ldu_to_coo_sparsity_builder_unit lcsb_checker u_lcsb_checker (.*);
